@@ hdl/fpd_pkg.sv @@
// Shared widths, reset values, register map and result structs of the
// frequency-to-duty block. No dependencies.
package fpd_pkg;

    localparam int STAMP_BITS  = 16;
    localparam int STAMP_IN_W  = 16;
    localparam int CLK_W       = 27;
    localparam int TOP_W       = 16;
    localparam int MUL_B_W     = (STAMP_BITS > TOP_W) ? STAMP_BITS : TOP_W;
    localparam int PROD_W      = CLK_W + MUL_B_W;
    localparam int MUL_STEPS   = MUL_B_W;
    localparam int MUL_CNT_W   = $clog2(MUL_STEPS);
    localparam int QUOT_W      = TOP_W + 1;
    localparam int DIV_STEPS   = QUOT_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int DVS_W       = PROD_W + TOP_W;

    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_W   = 2;

    localparam logic [REG_IDX_W-1:0] REG_CLOCK_HZ      = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FULL_SCALE_HZ = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_PWM_TOP       = 2'd2;

    localparam logic [CLK_W-1:0] CLOCK_HZ_RST      = CLK_W'(48000000);
    localparam logic [CLK_W-1:0] FULL_SCALE_HZ_RST = CLK_W'(200000);
    localparam logic [TOP_W-1:0] PWM_TOP_RST       = TOP_W'(100);

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] prod;
    } t_mul_res;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_div_res;

endpackage

@@ hdl/frequency_to_pwm_duty.sv @@
// Top level: APB registers, capture state, sequencing of the serial multiply
// and divide units, and the result register. Depends on fpd_pkg, fpd_mul, fpd_div.
//
//  Channel   Signals                                        Direction
//  input     i_in_valid / o_in_ready, i_command,            in
//            i_timestamp, i_select_level
//  output    o_out_valid / i_out_ready, o_compare_a,        out
//            o_compare_b
//  config    psel, penable, pwrite, paddr, pwdata, prdata   APB slave
//
// A result is registered after its input beat passes a registered start, the
// 16-step serial multipliers, a registered hand-over, the 17-step divider, the
// registered clamped duty and the compare registers. No new beat is taken until
// the item has moved to the output register. The next item is accepted while a
// finished result still waits there; one that finds it full waits on i_out_ready.
// Reset is synchronous and active low and restores the register defaults.
module frequency_to_pwm_duty
    import fpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_command,
    input  logic [STAMP_IN_W-1:0] i_timestamp,
    input  logic                  i_select_level,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [TOP_W-1:0]      o_compare_a,
    output logic [TOP_W-1:0]      o_compare_b,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]            r_state;
    logic [CLK_W-1:0]      r_clock_hz;
    logic [CLK_W-1:0]      r_full_scale_hz;
    logic [TOP_W-1:0]      r_top;
    logic [STAMP_BITS-1:0] r_last_stamp;
    logic [STAMP_BITS-1:0] r_period;
    logic                  r_sel;
    logic                  r_mul_start;
    logic                  r_div_start;
    logic [TOP_W-1:0]      r_duty;
    logic                  r_out_valid;
    logic [TOP_W-1:0]      r_compare_a;
    logic [TOP_W-1:0]      r_compare_b;

    logic                  in_beat;
    logic                  cfg_write;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic [STAMP_BITS-1:0] n_delta;
    logic [TOP_W-1:0]      n_duty;
    logic                  n_out_valid;
    logic                  out_free;
    t_mul_res              num_res;
    t_mul_res              den_res;
    t_div_res              div_res;

    assign pready      = 1'b1;
    assign reg_idx     = paddr[APB_ADDR_W-1:2];
    assign cfg_write   = psel && penable && pwrite;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_beat     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign n_out_valid = (r_state == S_OUT && out_free) || (r_out_valid && !i_out_ready);
    assign n_delta     = STAMP_BITS'(i_timestamp) - r_last_stamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz      <= CLOCK_HZ_RST;
            r_full_scale_hz <= FULL_SCALE_HZ_RST;
            r_top           <= PWM_TOP_RST;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_CLOCK_HZ:      r_clock_hz      <= pwdata[CLK_W-1:0];
                REG_FULL_SCALE_HZ: r_full_scale_hz <= pwdata[CLK_W-1:0];
                REG_PWM_TOP:       r_top           <= pwdata[TOP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_CLOCK_HZ:      prdata = APB_DATA_W'(r_clock_hz);
            REG_FULL_SCALE_HZ: prdata = APB_DATA_W'(r_full_scale_hz);
            REG_PWM_TOP:       prdata = APB_DATA_W'(r_top);
            default:           prdata = '0;
        endcase
    end

    fpd_mul u_num_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_a     (r_clock_hz),
        .i_b     (MUL_B_W'(r_top)),
        .o_res   (num_res)
    );

    fpd_mul u_den_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_a     (r_full_scale_hz),
        .i_b     (MUL_B_W'(r_period)),
        .o_res   (den_res)
    );

    fpd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (num_res.prod),
        .i_den   (den_res.prod),
        .o_res   (div_res)
    );

    // No period yet gives zero duty; a zero divisor or a quotient above the top value saturates at the top value.
    always_comb begin
        priority if (r_period == '0) begin
            n_duty = '0;
        end else if (den_res.prod == '0) begin
            n_duty = r_top;
        end else if (div_res.quot > QUOT_W'(r_top)) begin
            n_duty = r_top;
        end else begin
            n_duty = div_res.quot[TOP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_last_stamp <= '0;
            r_period     <= '0;
            r_mul_start  <= 1'b0;
            r_div_start  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_mul_start <= in_beat;
            r_div_start <= (r_state == S_MUL) && num_res.done;
            r_out_valid <= n_out_valid;
            unique case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        if (!i_command) begin
                            r_last_stamp <= STAMP_BITS'(i_timestamp);
                            if (n_delta != '0) begin
                                r_period <= n_delta;
                            end
                        end
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (num_res.done) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_res.done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_sel <= i_select_level;
        end
        if (r_state == S_DIV && div_res.done) begin
            r_duty <= n_duty;
        end
        if (r_state == S_OUT && out_free) begin
            r_compare_a <= r_sel ? r_duty : '0;
            r_compare_b <= r_sel ? '0 : r_duty;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_compare_a = r_compare_a;
    assign o_compare_b = r_compare_b;

    a_mul_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        num_res.done == den_res.done)
        else $error("multipliers finished out of step");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_res.done |-> r_state == S_DIV)
        else $error("divider finished outside the divide phase");

    a_one_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_compare_a == '0 || o_compare_b == '0))
        else $error("both compare channels driven");

    a_duty_le_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && div_res.done) |=> r_duty <= r_top)
        else $error("duty above the top value");

endmodule

@@ hdl/fpd_mul.sv @@
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on fpd_pkg.
module fpd_mul
    import fpd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [CLK_W-1:0]   i_a,
    input  logic [MUL_B_W-1:0] i_b,
    output t_mul_res           o_res
);

    logic                 r_busy;
    logic                 r_done;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic [PROD_W-1:0]    r_acc;
    logic [PROD_W-1:0]    r_mcand;
    logic [MUL_B_W-1:0]   r_mplier;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == MUL_CNT_W'(MUL_STEPS - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + MUL_CNT_W'(1);
                if (r_cnt == MUL_CNT_W'(MUL_STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // The multiplicand walks left while the multiplier shifts out LSB first.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc    <= '0;
            r_mcand  <= PROD_W'(i_a);
            r_mplier <= i_b;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= r_mcand << 1;
            r_mplier <= r_mplier >> 1;
        end
    end

    assign o_res.done = r_done;
    assign o_res.prod = r_acc;

endmodule

@@ hdl/fpd_div.sv @@
// Restoring divider producing one quotient bit per cycle, with one extra
// leading bit that flags a quotient beyond the compare range. Depends on fpd_pkg.
module fpd_div
    import fpd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PROD_W-1:0] i_num,
    input  logic [PROD_W-1:0] i_den,
    output t_div_res          o_res
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [PROD_W-1:0]    r_rem;
    logic [DVS_W-1:0]     r_dvs;
    logic [QUOT_W-1:0]    r_quot;
    logic                 fits;

    assign fits = ({TOP_W'(0), r_rem} >= r_dvs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // The divisor starts at its highest weight and moves right one bit a step.
    // When it fits, it is no larger than the remainder, so its low part suffices.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_dvs  <= {i_den, TOP_W'(0)};
            r_quot <= '0;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= r_rem - r_dvs[PROD_W-1:0];
            end
            r_quot <= {r_quot[QUOT_W-2:0], fits};
            r_dvs  <= r_dvs >> 1;
        end
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_quot;

endmodule
